/* rtl/mrtu_pkg.sv */
package mrtu_pkg;

	// Storage sizes
	localparam int FRAME_BYTES = 256;
	localparam int COIL_DEPTH  = 2048;
	localparam int REG_DEPTH   = 256;

	localparam int FA  = $clog2(FRAME_BYTES);        // frame buffer address
	localparam int NW  = $clog2(FRAME_BYTES + 1);    // frame byte count
	localparam int CA  = $clog2(COIL_DEPTH);
	localparam int RA  = $clog2(REG_DEPTH);
	localparam int CLR_DEPTH = (COIL_DEPTH > REG_DEPTH) ? COIL_DEPTH : REG_DEPTH;
	localparam int CLW = $clog2(CLR_DEPTH);
	localparam int TW  = (NW > 9) ? NW : 9;          // expected frame length compare

	// Header bytes kept aside while a request comes in
	localparam int HDR_BYTES = 7;
	localparam int HIW       = $clog2(HDR_BYTES);

	// Quantity limits
	localparam int QTY_COILS_MAX  = 2000;
	localparam int QTY_REGS_MAX   = 125;
	localparam int QTY_WMULTI_MAX = 123;
	localparam int QW  = $clog2(QTY_COILS_MAX + 1);
	localparam int IW2 = QW + 1;

	localparam int MIN_FRAME  = 4;
	localparam int MIN_WMULTI = 7;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int COIL_CNT_W = 12;
	localparam int REG_CNT_W  = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_STATION_ID = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COIL_BASE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COIL_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REG_BASE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT  = 3'd4;

	// Input actions
	localparam logic [1:0] ACT_BYTE = 2'd0;
	localparam logic [1:0] ACT_END  = 2'd1;
	localparam logic [1:0] ACT_PULL = 2'd2;

	// Result kinds, verdicts, exceptions
	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic [1:0] VERD_NORMAL    = 2'd0;
	localparam logic [1:0] VERD_EXCEPTION = 2'd1;
	localparam logic [1:0] VERD_OTHER     = 2'd2;
	localparam logic [1:0] VERD_BAD       = 2'd3;

	localparam logic [1:0] EXC_NONE  = 2'd0;
	localparam logic [1:0] EXC_FUNC  = 2'd1;
	localparam logic [1:0] EXC_ADDR  = 2'd2;
	localparam logic [1:0] EXC_VALUE = 2'd3;

	// Function codes
	localparam logic [7:0] FC_RD_COILS    = 8'd1;
	localparam logic [7:0] FC_RD_DISCRETE = 8'd2;
	localparam logic [7:0] FC_RD_HOLDING  = 8'd3;
	localparam logic [7:0] FC_RD_INPUT    = 8'd4;
	localparam logic [7:0] FC_WR_COIL     = 8'd5;
	localparam logic [7:0] FC_WR_REG      = 8'd6;
	localparam logic [7:0] FC_WR_MULTI    = 8'd16;
	localparam logic [7:0] FC_EXC_FLAG    = 8'h80;

	localparam logic [15:0] COIL_ON  = 16'hFF00;
	localparam logic [15:0] COIL_OFF = 16'h0000;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Response path chosen at frame end
	typedef enum logic [2:0] {
		PATH_DROP,
		PATH_EXC,
		PATH_RD_COIL,
		PATH_RD_REG,
		PATH_WR_COIL,
		PATH_WR_REG,
		PATH_WR_MULTI
	} path_t;

	// Datapath operations
	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_RX,
		OP_EVAL,
		OP_WCOIL,
		OP_WREG,
		OP_WRDH,
		OP_WRDL,
		OP_WWR,
		OP_HDR,
		OP_CRD,
		OP_CACC,
		OP_CEMIT,
		OP_RRD,
		OP_RHI,
		OP_RLO,
		OP_CRCL,
		OP_CRCH,
		OP_VERD,
		OP_PRD,
		OP_POUT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic  clr_last;
		logic  hdr_last;
		logic  last_item;
		logic  all_done;
		logic  byte_end;
		logic  out_free;
		logic  pull_avail;
		path_t path;
	} status_t;

	function automatic logic [15:0] crc16_upd(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Range lies inside the window from base and does not pass the top of the address space
	function automatic logic range_ok(input logic [15:0] a, input logic [15:0] q,
			input logic [15:0] base, input logic [16:0] lim);
		logic [16:0] end_abs;
		logic [16:0] end_rel;
		end_abs = {1'b0, a} + {1'b0, q};
		end_rel = {1'b0, a - base} + {1'b0, q};
		return (a >= base) && (end_abs <= 17'h10000) && (end_rel <= lim);
	endfunction

endpackage

/* rtl/mrtu_ram.sv */
module mrtu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/mrtu_ctrl.sv */
module mrtu_ctrl import mrtu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_fire,
	input  logic [1:0] action,
	input  status_t st,
	output logic    in_ready,
	output cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_RX, S_EVAL, S_DISP,
		S_WCOIL, S_WREG, S_WRDH, S_WRDL, S_WWR,
		S_HDR, S_CRD, S_CACC, S_CEMIT, S_RRD, S_RHI, S_RLO,
		S_CRCL, S_CRCH, S_VERD, S_PRD, S_POUT
	} state_t;

	state_t state_q, state_d;

	function automatic op_t op_of(input state_t s);
		case (s)
			S_CLEAR: return OP_CLEAR;
			S_RX:    return OP_RX;
			S_EVAL:  return OP_EVAL;
			S_WCOIL: return OP_WCOIL;
			S_WREG:  return OP_WREG;
			S_WRDH:  return OP_WRDH;
			S_WRDL:  return OP_WRDL;
			S_WWR:   return OP_WWR;
			S_HDR:   return OP_HDR;
			S_CRD:   return OP_CRD;
			S_CACC:  return OP_CACC;
			S_CEMIT: return OP_CEMIT;
			S_RRD:   return OP_RRD;
			S_RHI:   return OP_RHI;
			S_RLO:   return OP_RLO;
			S_CRCL:  return OP_CRCL;
			S_CRCH:  return OP_CRCH;
			S_VERD:  return OP_VERD;
			S_PRD:   return OP_PRD;
			S_POUT:  return OP_POUT;
			default: return OP_NONE;
		endcase
	endfunction

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (st.clr_last) state_d = S_IDLE;
			S_IDLE: begin
				if (in_fire) begin
					case (action)
						ACT_BYTE: state_d = S_RX;
						ACT_END:  state_d = S_EVAL;
						ACT_PULL: state_d = st.pull_avail ? S_PRD : S_IDLE;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_RX:   state_d = S_IDLE;
			S_EVAL: state_d = S_DISP;
			S_DISP: begin
				case (st.path)
					PATH_DROP:     state_d = S_VERD;
					PATH_WR_COIL:  state_d = S_WCOIL;
					PATH_WR_REG:   state_d = S_WREG;
					PATH_WR_MULTI: state_d = S_WRDH;
					default:       state_d = S_HDR;
				endcase
			end
			S_WCOIL: state_d = S_HDR;
			S_WREG:  state_d = S_HDR;
			S_WRDH:  state_d = S_WRDL;
			S_WRDL:  state_d = S_WWR;
			S_WWR:   state_d = st.last_item ? S_HDR : S_WRDH;
			S_HDR: begin
				if (st.hdr_last) begin
					case (st.path)
						PATH_RD_COIL: state_d = S_CRD;
						PATH_RD_REG:  state_d = S_RRD;
						default:      state_d = S_CRCL;
					endcase
				end
			end
			S_CRD:   state_d = S_CACC;
			S_CACC:  state_d = st.byte_end ? S_CEMIT : S_CRD;
			S_CEMIT: state_d = st.all_done ? S_CRCL : S_CRD;
			S_RRD:   state_d = S_RHI;
			S_RHI:   state_d = S_RLO;
			S_RLO:   state_d = st.last_item ? S_CRCL : S_RRD;
			S_CRCL:  state_d = S_CRCH;
			S_CRCH:  state_d = S_VERD;
			S_VERD:  if (st.out_free) state_d = S_IDLE;
			S_PRD:   state_d = S_POUT;
			S_POUT:  if (st.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cmd.op  <= OP_CLEAR;
		end else begin
			state_q <= state_d;
			cmd.op  <= op_of(state_d);
		end
	end

endmodule

/* rtl/mrtu_datapath.sv */
module mrtu_datapath import mrtu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_fire,
	input  logic [7:0]            rx_byte,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  out_ready,
	input  cmd_t                  cmd,
	output status_t               st,
	output logic                  out_valid,
	output logic                  result_kind,
	output logic [7:0]            tx_byte,
	output logic                  last_byte,
	output logic [1:0]            verdict,
	output logic [1:0]            exception_code
);

	// Configuration
	logic [7:0]            station_q;
	logic [15:0]           coil_base_q;
	logic [COIL_CNT_W-1:0] coil_count_q;
	logic [15:0]           reg_base_q;
	logic [REG_CNT_W-1:0]  reg_count_q;

	// Receive side
	logic [7:0]    byte_q;
	logic [NW-1:0] rx_cnt_q;
	logic          rx_ovf_q;
	logic [15:0]   rx_crc_q;
	logic [7:0]    hdr_q [HDR_BYTES];
	logic [7:0]    lb_a_q, lb_b_q;
	logic          rx_store;

	// Frame-end evaluation
	logic [1:0] verd_q, exc_q;
	path_t      path_q;
	logic [1:0] ev_verd, ev_exc, fexc;
	path_t      ev_path, npath;

	// Response build
	logic [2:0]    idx_q;
	logic [QW-1:0] i_q;
	logic [7:0]    acc_q, hi_q;
	logic [NW-1:0] tx_wp_q, tx_len_q, tx_ptr_q;
	logic [15:0]   tx_crc_q;
	logic [CLW-1:0] clr_q;

	// Output register
	logic       out_valid_q, out_kind_q, out_last_q;
	logic [7:0] out_byte_q;
	logic [1:0] out_verd_q, out_exc_q;
	logic       out_free, out_load;

	// Decoded request fields
	logic [7:0]  fc;
	logic [15:0] addr, val;
	logic [16:0] bc17, two_q, coil_lim, reg_lim;
	logic        fc_std, fc16, len_ok, crc_ok;
	logic [TW-1:0] t_plus2;
	logic        coil_rng_q, coil_rng_1, reg_rng_q, reg_rng_1;

	// RAM connections
	logic          rx_re, tx_we, tx_re, coil_we, coil_re, reg_we, reg_re, crc_upd;
	logic [FA-1:0] rx_raddr;
	logic [7:0]    rx_rdata, tx_wdata, tx_rdata, hdr_byte;
	logic [CA-1:0] coil_addr, coil_waddr;
	logic          coil_wdata, coil_rdata;
	logic [RA-1:0] reg_addr, reg_waddr;
	logic [15:0]   reg_wdata, reg_rdata;
	logic [IW2-1:0] i2;

	assign fc   = hdr_q[1];
	assign addr = {hdr_q[2], hdr_q[3]};
	assign val  = {hdr_q[4], hdr_q[5]};
	assign bc17 = (17'(val) + 17'd7) >> 3;
	assign two_q = {val, 1'b0};
	assign coil_lim = (17'(coil_count_q) < 17'(COIL_DEPTH)) ? 17'(coil_count_q) : 17'(COIL_DEPTH);
	assign reg_lim  = (17'(reg_count_q) < 17'(REG_DEPTH)) ? 17'(reg_count_q) : 17'(REG_DEPTH);
	assign fc_std = (fc inside {[FC_RD_COILS:FC_WR_REG]});
	assign fc16   = (fc == FC_WR_MULTI);
	assign t_plus2 = fc16 ? (TW'(hdr_q[6]) + TW'(MIN_WMULTI + 2)) : TW'(8);
	assign len_ok = (TW'(rx_cnt_q) == t_plus2);
	assign crc_ok = (lb_a_q == rx_crc_q[7:0] && lb_b_q == rx_crc_q[15:8]) ||
			(lb_a_q == rx_crc_q[15:8] && lb_b_q == rx_crc_q[7:0]);
	assign coil_rng_q = range_ok(addr, val, coil_base_q, coil_lim);
	assign coil_rng_1 = range_ok(addr, 16'd1, coil_base_q, coil_lim);
	assign reg_rng_q  = range_ok(addr, val, reg_base_q, reg_lim);
	assign reg_rng_1  = range_ok(addr, 16'd1, reg_base_q, reg_lim);

	always_comb begin
		ev_verd = VERD_BAD;
		ev_exc  = EXC_NONE;
		ev_path = PATH_DROP;
		fexc    = EXC_NONE;
		npath   = PATH_DROP;
		if (rx_cnt_q == '0 || rx_ovf_q) begin
			ev_verd = VERD_BAD;
		end else if (hdr_q[0] != station_q) begin
			ev_verd = VERD_OTHER;
		end else if (rx_cnt_q < NW'(MIN_FRAME)) begin
			ev_verd = VERD_BAD;
		end else if (!fc_std && !fc16) begin
			ev_verd = VERD_EXCEPTION;
			ev_exc  = EXC_FUNC;
			ev_path = PATH_EXC;
		end else if (fc16 && rx_cnt_q < NW'(MIN_WMULTI)) begin
			ev_verd = VERD_BAD;
		end else if (!len_ok || !crc_ok) begin
			ev_verd = VERD_BAD;
		end else begin
			case (fc)
				FC_RD_COILS, FC_RD_DISCRETE: begin
					if (val == '0 || val > 16'(QTY_COILS_MAX) ||
							bc17 + 17'd5 > 17'(FRAME_BYTES)) fexc = EXC_VALUE;
					else if (!coil_rng_q) fexc = EXC_ADDR;
					else npath = PATH_RD_COIL;
				end
				FC_RD_HOLDING, FC_RD_INPUT: begin
					if (val == '0 || val > 16'(QTY_REGS_MAX) ||
							two_q + 17'd5 > 17'(FRAME_BYTES)) fexc = EXC_VALUE;
					else if (!reg_rng_q) fexc = EXC_ADDR;
					else npath = PATH_RD_REG;
				end
				FC_WR_COIL: begin
					if (!coil_rng_1) fexc = EXC_ADDR;
					else if (val != COIL_ON && val != COIL_OFF) fexc = EXC_VALUE;
					else npath = PATH_WR_COIL;
				end
				FC_WR_REG: begin
					if (!reg_rng_1) fexc = EXC_ADDR;
					else npath = PATH_WR_REG;
				end
				default: begin
					if (val == '0 || val > 16'(QTY_WMULTI_MAX) ||
							17'(hdr_q[6]) != two_q) fexc = EXC_VALUE;
					else if (!reg_rng_q) fexc = EXC_ADDR;
					else npath = PATH_WR_MULTI;
				end
			endcase
			if (fexc != EXC_NONE) begin
				ev_verd = VERD_EXCEPTION;
				ev_exc  = fexc;
				ev_path = PATH_EXC;
			end else begin
				ev_verd = VERD_NORMAL;
				ev_path = npath;
			end
		end
	end

	// Header byte of the response
	always_comb begin
		case (idx_q)
			3'd0: hdr_byte = hdr_q[0];
			3'd1: hdr_byte = (path_q == PATH_EXC) ? (fc | FC_EXC_FLAG) : fc;
			3'd2: begin
				case (path_q)
					PATH_EXC:     hdr_byte = {6'b0, exc_q};
					PATH_RD_COIL: hdr_byte = bc17[7:0];
					PATH_RD_REG:  hdr_byte = two_q[7:0];
					default:      hdr_byte = hdr_q[2];
				endcase
			end
			3'd3:    hdr_byte = hdr_q[3];
			3'd4:    hdr_byte = hdr_q[4];
			default: hdr_byte = hdr_q[5];
		endcase
	end

	always_comb begin
		tx_we    = 1'b1;
		crc_upd  = 1'b1;
		case (cmd.op)
			OP_HDR:   tx_wdata = hdr_byte;
			OP_CEMIT: tx_wdata = acc_q;
			OP_RHI:   tx_wdata = reg_rdata[15:8];
			OP_RLO:   tx_wdata = reg_rdata[7:0];
			OP_CRCL: begin
				tx_wdata = tx_crc_q[7:0];
				crc_upd  = 1'b0;
			end
			OP_CRCH: begin
				tx_wdata = tx_crc_q[15:8];
				crc_upd  = 1'b0;
			end
			default: begin
				tx_wdata = 8'h00;
				tx_we    = 1'b0;
				crc_upd  = 1'b0;
			end
		endcase
	end

	assign i2        = {i_q, 1'b0};
	assign rx_re     = (cmd.op == OP_WRDH) || (cmd.op == OP_WRDL);
	assign rx_raddr  = (cmd.op == OP_WRDL) ? FA'(i2 + IW2'(MIN_WMULTI + 1)) :
			FA'(i2 + IW2'(MIN_WMULTI));
	assign rx_store  = (cmd.op == OP_RX) && (rx_cnt_q < NW'(FRAME_BYTES));
	assign tx_re     = (cmd.op == OP_PRD);
	assign coil_addr = CA'(addr - coil_base_q) + CA'(i_q);
	assign reg_addr  = RA'(addr - reg_base_q) + RA'(i_q);
	assign coil_re   = (cmd.op == OP_CRD);
	assign reg_re    = (cmd.op == OP_RRD);
	assign coil_we   = (cmd.op == OP_CLEAR) || (cmd.op == OP_WCOIL);
	assign coil_waddr = (cmd.op == OP_CLEAR) ? clr_q[CA-1:0] : coil_addr;
	assign coil_wdata = (cmd.op == OP_WCOIL) && (val == COIL_ON);
	assign reg_we    = (cmd.op == OP_CLEAR) || (cmd.op == OP_WREG) || (cmd.op == OP_WWR);
	assign reg_waddr = (cmd.op == OP_CLEAR) ? clr_q[RA-1:0] : reg_addr;
	always_comb begin
		case (cmd.op)
			OP_WREG: reg_wdata = val;
			OP_WWR:  reg_wdata = {hi_q, rx_rdata};
			default: reg_wdata = 16'h0000;
		endcase
	end

	mrtu_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_rx_ram (
		.clk(clk), .we(rx_store), .waddr(rx_cnt_q[FA-1:0]), .wdata(byte_q),
		.re(rx_re), .raddr(rx_raddr), .rdata(rx_rdata)
	);

	mrtu_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_tx_ram (
		.clk(clk), .we(tx_we), .waddr(tx_wp_q[FA-1:0]), .wdata(tx_wdata),
		.re(tx_re), .raddr(tx_ptr_q[FA-1:0]), .rdata(tx_rdata)
	);

	mrtu_ram #(.WIDTH(1), .DEPTH(COIL_DEPTH)) u_coil_ram (
		.clk(clk), .we(coil_we), .waddr(coil_waddr), .wdata(coil_wdata),
		.re(coil_re), .raddr(coil_addr), .rdata(coil_rdata)
	);

	mrtu_ram #(.WIDTH(16), .DEPTH(REG_DEPTH)) u_reg_ram (
		.clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
		.re(reg_re), .raddr(reg_addr), .rdata(reg_rdata)
	);

	assign out_free = !out_valid_q || out_ready;
	assign out_load = out_free && ((cmd.op == OP_VERD) || (cmd.op == OP_POUT));

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q    <= 8'd1;
			coil_base_q  <= '0;
			coil_count_q <= COIL_CNT_W'(COIL_DEPTH);
			reg_base_q   <= '0;
			reg_count_q  <= REG_CNT_W'(REG_DEPTH);
			rx_cnt_q     <= '0;
			rx_ovf_q     <= 1'b0;
			rx_crc_q     <= CRC_INIT;
			verd_q       <= VERD_NORMAL;
			exc_q        <= EXC_NONE;
			path_q       <= PATH_DROP;
			idx_q        <= '0;
			i_q          <= '0;
			tx_wp_q      <= '0;
			tx_crc_q     <= CRC_INIT;
			tx_len_q     <= '0;
			tx_ptr_q     <= '0;
			clr_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_STATION_ID: station_q    <= cfg_wdata[7:0];
					CFG_COIL_BASE:  coil_base_q  <= cfg_wdata;
					CFG_COIL_COUNT: coil_count_q <= cfg_wdata[COIL_CNT_W-1:0];
					CFG_REG_BASE:   reg_base_q   <= cfg_wdata;
					CFG_REG_COUNT:  reg_count_q  <= cfg_wdata[REG_CNT_W-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (tx_we) begin
				tx_wp_q <= tx_wp_q + 1'b1;
				if (crc_upd) tx_crc_q <= crc16_upd(tx_crc_q, tx_wdata);
			end

			case (cmd.op)
				OP_CLEAR: clr_q <= clr_q + 1'b1;
				OP_RX: begin
					if (rx_store) begin
						rx_cnt_q <= rx_cnt_q + 1'b1;
						if (rx_cnt_q >= NW'(2)) rx_crc_q <= crc16_upd(rx_crc_q, lb_a_q);
					end else begin
						rx_ovf_q <= 1'b1;
					end
				end
				OP_EVAL: begin
					verd_q   <= ev_verd;
					exc_q    <= ev_exc;
					path_q   <= ev_path;
					rx_cnt_q <= '0;
					rx_ovf_q <= 1'b0;
					rx_crc_q <= CRC_INIT;
					idx_q    <= '0;
					i_q      <= '0;
					tx_wp_q  <= '0;
					tx_crc_q <= CRC_INIT;
					tx_len_q <= '0;
					tx_ptr_q <= '0;
				end
				OP_HDR:  idx_q <= idx_q + 1'b1;
				OP_CACC, OP_RLO, OP_WWR: i_q <= i_q + 1'b1;
				OP_CRCH: tx_len_q <= tx_wp_q + 1'b1;
				OP_POUT: if (out_free) tx_ptr_q <= tx_ptr_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_fire) byte_q <= rx_byte;
		if (rx_store) begin
			lb_a_q <= lb_b_q;
			lb_b_q <= byte_q;
			if (rx_cnt_q < NW'(HDR_BYTES)) hdr_q[rx_cnt_q[HIW-1:0]] <= byte_q;
		end
		case (cmd.op)
			OP_EVAL, OP_CEMIT: acc_q <= 8'h00;
			OP_CACC:           acc_q[i_q[2:0]] <= coil_rdata;
			OP_WRDL:           hi_q <= rx_rdata;
			default: ;
		endcase
		if (out_load) begin
			if (cmd.op == OP_VERD) begin
				out_kind_q <= KIND_VERDICT;
				out_byte_q <= 8'h00;
				out_last_q <= 1'b0;
				out_verd_q <= verd_q;
				out_exc_q  <= exc_q;
			end else begin
				out_kind_q <= KIND_BYTE;
				out_byte_q <= tx_rdata;
				out_last_q <= (tx_ptr_q + 1'b1 == tx_len_q);
				out_verd_q <= VERD_NORMAL;
				out_exc_q  <= EXC_NONE;
			end
		end
	end

	assign st.clr_last   = (clr_q == CLW'(CLR_DEPTH - 1));
	assign st.hdr_last   = (idx_q == (((path_q == PATH_EXC) || (path_q == PATH_RD_COIL) ||
			(path_q == PATH_RD_REG)) ? 3'd2 : 3'd5));
	assign st.last_item  = (17'(i_q) + 17'd1 == 17'(val));
	assign st.all_done   = (17'(i_q) == 17'(val));
	assign st.byte_end   = (i_q[2:0] == 3'd7) || st.last_item;
	assign st.out_free   = out_free;
	assign st.pull_avail = (tx_ptr_q < tx_len_q);
	assign st.path       = path_q;

	assign out_valid      = out_valid_q;
	assign result_kind    = out_kind_q;
	assign tx_byte        = out_byte_q;
	assign last_byte      = out_last_q;
	assign verdict        = out_verd_q;
	assign exception_code = out_exc_q;

	a_ptr_in_len: assert property (@(posedge clk) disable iff (!arst_n)
		tx_ptr_q <= tx_len_q)
		else $error("response pointer passed response length");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		rx_ovf_q |-> (rx_cnt_q == NW'(FRAME_BYTES)))
		else $error("overflow flagged with room left in the frame buffer");

	a_loop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_CACC || cmd.op == OP_RLO || cmd.op == OP_WWR) |->
		(17'(i_q) < 17'(val)))
		else $error("store walk ran past the requested quantity");

endmodule

/* rtl/modbus_rtu_server_frame_handler.sv */
// Modbus RTU server frame handler.
// Input channel (in_valid/in_ready) carries one transaction per action: a received
// byte, an end-of-frame gap, or a request to pull the next response byte.
// Output channel (out_valid/out_ready) carries a frame verdict after each
// end-of-frame, and one response byte per successful pull.
// Frame-end processing walks the stores one element at a time: coils are read
// and gathered into bytes, each register read is sent as high then low byte,
// and each register written is fetched as two received bytes and then stored.
// The response CRC is folded in as bytes are built.
// Reset clears the control state and runs a clearing pass over the coil and
// register stores; in_ready stays low during it. Configuration writes are taken
// at any time and take effect in the next cycle.
// A stalled receiver holds the pending result in the output register; received
// bytes keep being accepted meanwhile, but the next verdict or pulled byte waits
// in the controller, with in_ready low, until the output register is free.
module modbus_rtu_server_frame_handler import mrtu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            action,
	input  logic [7:0]            rx_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  result_kind,
	output logic [7:0]            tx_byte,
	output logic                  last_byte,
	output logic [1:0]            verdict,
	output logic [1:0]            exception_code,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cmd_t    cmd;
	status_t st;
	logic    in_fire;

	// a transaction is taken when both sides agree
	assign in_fire = in_valid && in_ready;

	// sequencing: receive, evaluate, walk stores, build response, pull
	mrtu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.action   (action),
		.st       (st),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// buffers, stores, CRC and the output register
	mrtu_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_fire        (in_fire),
		.rx_byte        (rx_byte),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.out_ready      (out_ready),
		.cmd            (cmd),
		.st             (st),
		.out_valid      (out_valid),
		.result_kind    (result_kind),
		.tx_byte        (tx_byte),
		.last_byte      (last_byte),
		.verdict        (verdict),
		.exception_code (exception_code)
	);

endmodule

/* sim/modbus_rtu_server_frame_handler_tb.sv */
module modbus_rtu_server_frame_handler_tb;
	import mrtu_pkg::*;

	// Action code that the block ignores
	localparam logic [1:0] ACT_SPARE = 2'd3;

	// Cycles to let pass before a register write
	localparam int SETTLE_CYCLES = 4200;
	localparam int HOLD_CYCLES   = 3000;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 190;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic       last;
		logic [1:0] verd;
		logic [1:0] exc;
	} reply_t;

	// Mirror of the server: its own stores and registers, and the replies still owed
	class server_mirror;
		logic [7:0]  station;
		logic [15:0] coil_base;
		logic [11:0] coil_cnt;
		logic [15:0] reg_base;
		logic [8:0]  reg_cnt;
		logic [7:0]  rx_buf [FRAME_BYTES];
		int unsigned rx_len;
		bit          rx_over;
		bit          coils [COIL_DEPTH];
		logic [15:0] regs [REG_DEPTH];
		logic [7:0]  tx_buf [FRAME_BYTES];
		int unsigned tx_len;
		int unsigned tx_ptr;
		reply_t      owed [$];
		int          errors;

		function new();
			station   = 8'd1;
			coil_base = 16'd0;
			coil_cnt  = 12'd2048;
			reg_base  = 16'd0;
			reg_cnt   = 9'd256;
			rx_len    = 0;
			rx_over   = 0;
			tx_len    = 0;
			tx_ptr    = 0;
			errors    = 0;
			foreach (coils[i]) coils[i] = 1'b0;
			foreach (regs[i]) regs[i] = 16'h0000;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				CFG_STATION_ID: station   = v[7:0];
				CFG_COIL_BASE:  coil_base = v;
				CFG_COIL_COUNT: coil_cnt  = v[11:0];
				CFG_REG_BASE:   reg_base  = v;
				CFG_REG_COUNT:  reg_cnt   = v[8:0];
				default: ;
			endcase
		endfunction

		static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
			logic [15:0] r;
			r = c ^ {8'h00, b};
			for (int k = 0; k < 8; k++)
				r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
			return r;
		endfunction

		static function bit span_ok(int unsigned a, int unsigned q, int unsigned base,
				int unsigned cnt, int unsigned depth);
			int unsigned lim;
			lim = (cnt < depth) ? cnt : depth;
			if (a < base || a + q > 65536)
				return 0;
			return (a - base) + q <= lim;
		endfunction

		// Judge the collected request and build the answer in tx_buf
		function void close_frame(output logic [1:0] verd, output logic [1:0] exc);
			int unsigned n, fc, t, addr, val, q, bc, len;
			logic [1:0]  code;
			logic [15:0] crc;
			verd = VERD_BAD;
			exc  = EXC_NONE;
			n    = rx_len;
			code = EXC_NONE;
			len  = 0;
			t    = 0;
			if (n == 0 || rx_over)
				return;
			if (rx_buf[0] != station) begin
				verd = VERD_OTHER;
				return;
			end
			if (n < MIN_FRAME)
				return;
			fc = rx_buf[1];
			tx_buf[0] = rx_buf[0];
			tx_buf[1] = rx_buf[1];
			if (fc >= FC_RD_COILS && fc <= FC_WR_REG) begin
				t = 6;
			end else if (fc == FC_WR_MULTI) begin
				if (n < MIN_WMULTI)
					return;
				t = rx_buf[6] + 7;
			end else begin
				code = EXC_FUNC;
			end
			if (code == EXC_NONE) begin
				if (n != t + 2)
					return;
				crc = 16'hFFFF;
				for (int i = 0; i < t; i++)
					crc = crc_step(crc, rx_buf[i]);
				// CRC may arrive in either byte order
				if (!((rx_buf[t] == crc[7:0] && rx_buf[t+1] == crc[15:8]) ||
						(rx_buf[t] == crc[15:8] && rx_buf[t+1] == crc[7:0])))
					return;
				addr = {rx_buf[2], rx_buf[3]};
				val  = {rx_buf[4], rx_buf[5]};
				q    = val;
				if (fc == FC_RD_COILS || fc == FC_RD_DISCRETE) begin
					bc = (q + 7) >> 3;
					if (q == 0 || q > QTY_COILS_MAX || bc + 5 > FRAME_BYTES) begin
						code = EXC_VALUE;
					end else if (!span_ok(addr, q, coil_base, coil_cnt, COIL_DEPTH)) begin
						code = EXC_ADDR;
					end else begin
						for (int i = 0; i < bc; i++)
							tx_buf[3+i] = 8'h00;
						for (int i = 0; i < q; i++)
							if (coils[addr - coil_base + i])
								tx_buf[3 + i/8][i%8] = 1'b1;
						tx_buf[2] = bc;
						len = 3 + bc;
					end
				end else if (fc == FC_RD_HOLDING || fc == FC_RD_INPUT) begin
					if (q == 0 || q > QTY_REGS_MAX || 2*q + 5 > FRAME_BYTES) begin
						code = EXC_VALUE;
					end else if (!span_ok(addr, q, reg_base, reg_cnt, REG_DEPTH)) begin
						code = EXC_ADDR;
					end else begin
						for (int i = 0; i < q; i++) begin
							tx_buf[3 + 2*i] = regs[addr - reg_base + i][15:8];
							tx_buf[4 + 2*i] = regs[addr - reg_base + i][7:0];
						end
						tx_buf[2] = 2*q;
						len = 3 + 2*q;
					end
				end else if (fc == FC_WR_COIL) begin
					// address first, then the on/off value
					if (!span_ok(addr, 1, coil_base, coil_cnt, COIL_DEPTH))
						code = EXC_ADDR;
					else if (val == COIL_ON)
						coils[addr - coil_base] = 1'b1;
					else if (val == COIL_OFF)
						coils[addr - coil_base] = 1'b0;
					else
						code = EXC_VALUE;
				end else if (fc == FC_WR_REG) begin
					if (!span_ok(addr, 1, reg_base, reg_cnt, REG_DEPTH))
						code = EXC_ADDR;
					else
						regs[addr - reg_base] = val;
				end else begin
					if (q == 0 || q > QTY_WMULTI_MAX || rx_buf[6] != 2*q)
						code = EXC_VALUE;
					else if (!span_ok(addr, q, reg_base, reg_cnt, REG_DEPTH))
						code = EXC_ADDR;
					else
						for (int i = 0; i < q; i++)
							regs[addr - reg_base + i] = {rx_buf[7 + 2*i], rx_buf[8 + 2*i]};
				end
				// write responses echo address and value
				if (code == EXC_NONE && (fc == FC_WR_COIL || fc == FC_WR_REG ||
						fc == FC_WR_MULTI)) begin
					for (int i = 2; i < 6; i++)
						tx_buf[i] = rx_buf[i];
					len = 6;
				end
			end
			if (code != EXC_NONE) begin
				tx_buf[1] = rx_buf[1] | FC_EXC_FLAG;
				tx_buf[2] = code;
				len = 3;
			end
			crc = 16'hFFFF;
			for (int i = 0; i < len; i++)
				crc = crc_step(crc, tx_buf[i]);
			tx_buf[len]   = crc[7:0];
			tx_buf[len+1] = crc[15:8];
			tx_len = len + 2;
			tx_ptr = 0;
			exc    = code;
			verd   = (code != EXC_NONE) ? VERD_EXCEPTION : VERD_NORMAL;
		endfunction

		// Note one accepted input transaction
		function void take_item(logic [1:0] act, logic [7:0] b);
			logic [1:0] v, e;
			case (act)
				ACT_BYTE: begin
					if (rx_len < FRAME_BYTES) begin
						rx_buf[rx_len] = b;
						rx_len++;
					end else begin
						rx_over = 1;
					end
				end
				ACT_END: begin
					tx_len = 0;
					tx_ptr = 0;
					close_frame(v, e);
					rx_len  = 0;
					rx_over = 0;
					owed.push_back('{KIND_VERDICT, 8'h00, 1'b0, v, e});
				end
				ACT_PULL: begin
					if (tx_ptr < tx_len) begin
						owed.push_back('{KIND_BYTE, tx_buf[tx_ptr], tx_ptr + 1 == tx_len,
							VERD_NORMAL, EXC_NONE});
						tx_ptr++;
					end
				end
				default: ;
			endcase
		endfunction

		// Compare one accepted output transaction with the oldest reply owed
		function void match_reply(reply_t got);
			reply_t want;
			if (owed.size() == 0) begin
				$error("unexpected result: kind %0d byte %h verdict %0d", got.kind, got.data,
					got.verd);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (got.kind != want.kind) begin
				$error("result_kind: expected %0d, got %0d", want.kind, got.kind);
				errors++;
			end
			if (got.data != want.data) begin
				$error("tx_byte: expected %h, got %h", want.data, got.data);
				errors++;
			end
			if (got.last != want.last) begin
				$error("last_byte: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
			if (got.verd != want.verd) begin
				$error("verdict: expected %0d, got %0d", want.verd, got.verd);
				errors++;
			end
			if (got.exc != want.exc) begin
				$error("exception_code: expected %0d, got %0d", want.exc, got.exc);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            action;
	logic [7:0]            rx_byte;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  result_kind;
	logic [7:0]            tx_byte;
	logic                  last_byte;
	logic [1:0]            verdict;
	logic [1:0]            exception_code;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	server_mirror mirror = new();
	int unsigned  items_sent = 0;
	int unsigned  cycle_count = 0;
	// Long receiver hold-off: asked for by the stimulus, counted by the receiver
	int unsigned  hold_asks = 0;
	int unsigned  hold_served = 0;
	int unsigned  hold_left = 0;
	int unsigned  stall_left = 0;
	int unsigned  mood_left = 0;
	bit           calm = 0;
	int unsigned  ready_roll;

	modbus_rtu_server_frame_handler dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.tx_byte        (tx_byte),
		.last_byte      (last_byte),
		.verdict        (verdict),
		.exception_code (exception_code),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abandon a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver: alternate calm spells with random stalls; serve any long hold-off request
	always @(negedge clk) begin
		if (mood_left == 0) begin
			calm = ($urandom % 4) == 0;
			mood_left = $urandom_range(100, 600);
		end else begin
			mood_left--;
		end
		if (hold_served != hold_asks) begin
			hold_served = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (calm) begin
			out_ready <= 1'b1;
		end else begin
			ready_roll = $urandom % 100;
			if (ready_roll < 70) begin
				out_ready <= 1'b1;
			end else begin
				stall_left = (ready_roll < 95) ? $urandom_range(0, 3) : $urandom_range(10, 50);
				out_ready <= 1'b0;
			end
		end
	end

	// Check every output transaction against the mirror
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			mirror.match_reply('{result_kind, tx_byte, last_byte, verdict, exception_code});
	end

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom % 100;
		if (calm || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Offer one transaction and hold it until the block takes it
	task automatic put(input logic [1:0] act, input logic [7:0] b);
		int unsigned gap;
		gap = gap_len();
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		action   = act;
		rx_byte  = b;
		forever begin
			@(posedge clk);
			if (in_ready)
				break;
		end
		mirror.take_item(act, b);
		if (act != ACT_SPARE)
			items_sent++;
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = v;
		mirror.set_register(idx, v);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Drop valid, wait for every owed reply, then outlast a possible slow frame end
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (mirror.owed.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void add_crc(ref logic [7:0] f[$], input bit swap);
		logic [15:0] crc;
		crc = 16'hFFFF;
		foreach (f[i])
			crc = server_mirror::crc_step(crc, f[i]);
		if (swap) begin
			f.push_back(crc[15:8]);
			f.push_back(crc[7:0]);
		end else begin
			f.push_back(crc[7:0]);
			f.push_back(crc[15:8]);
		end
	endfunction

	// Mostly well-formed requests aimed at the current windows; the rest broken or noise
	function automatic void build_request(ref logic [7:0] f[$]);
		logic [7:0]  fc;
		logic [7:0]  bc;
		int unsigned pick, base, span, addr, val, r, cut, idx;
		bit          coil_side;
		f.delete();
		pick = $urandom_range(0, 99);
		if (pick >= 95) begin
			repeat ($urandom_range(0, 12)) f.push_back($urandom);
			if (f.size() != 0 && $urandom % 2)
				f[0] = mirror.station;
			return;
		end
		case ($urandom_range(0, 6))
			0: fc = FC_RD_COILS;
			1: fc = FC_RD_DISCRETE;
			2: fc = FC_RD_HOLDING;
			3: fc = FC_RD_INPUT;
			4: fc = FC_WR_COIL;
			5: fc = FC_WR_REG;
			default: fc = FC_WR_MULTI;
		endcase
		coil_side = fc == FC_RD_COILS || fc == FC_RD_DISCRETE || fc == FC_WR_COIL;
		base = coil_side ? mirror.coil_base : mirror.reg_base;
		span = coil_side ? mirror.coil_cnt : mirror.reg_cnt;
		r = $urandom % 10;
		if (r < 8)
			addr = (base + $urandom_range(0, span)) & 16'hFFFF;
		else if (r < 9)
			addr = (base + span - $urandom_range(0, 3)) & 16'hFFFF;
		else
			addr = $urandom & 16'hFFFF;
		r = $urandom % 20;
		if (fc == FC_RD_COILS || fc == FC_RD_DISCRETE)
			val = (r < 17) ? $urandom_range(1, 24) : (r == 17) ? 0 :
				(r == 18) ? $urandom_range(2001, 65535) : $urandom_range(1, QTY_COILS_MAX);
		else if (fc == FC_RD_HOLDING || fc == FC_RD_INPUT)
			val = (r < 17) ? $urandom_range(1, 8) : (r == 17) ? 0 :
				(r == 18) ? $urandom_range(126, 65535) : $urandom_range(1, QTY_REGS_MAX);
		else if (fc == FC_WR_COIL)
			val = (r < 9) ? COIL_ON : (r < 18) ? COIL_OFF : $urandom & 16'hFFFF;
		else if (fc == FC_WR_REG)
			val = $urandom & 16'hFFFF;
		else
			val = (r < 17) ? $urandom_range(1, 6) : (r == 17) ? 0 :
				(r == 18) ? $urandom_range(124, 300) : $urandom_range(1, QTY_WMULTI_MAX);
		if (pick >= 80 && pick < 85) begin
			do fc = $urandom; while (fc inside {FC_RD_COILS, FC_RD_DISCRETE, FC_RD_HOLDING,
				FC_RD_INPUT, FC_WR_COIL, FC_WR_REG, FC_WR_MULTI});
		end
		f = '{mirror.station, fc, addr[15:8], addr[7:0], val[15:8], val[7:0]};
		if (fc == FC_WR_MULTI) begin
			bc = ($urandom % 10 == 0) ? $urandom_range(0, 20) : 2*val;
			f.push_back(bc);
			repeat (bc) f.push_back($urandom);
		end
		add_crc(f, $urandom % 2);
		if (pick >= 75 && pick < 80) begin
			f[0] = mirror.station ^ $urandom_range(1, 255);
		end else if (pick >= 85 && pick < 90) begin
			idx = $urandom_range(0, f.size() - 1);
			f[idx][$urandom_range(0, 7)] = ~f[idx][$urandom_range(0, 7)];
			f[idx] = f[idx] ^ (8'h01 << $urandom_range(0, 7));
		end else if (pick >= 90 && pick < 95) begin
			cut = $urandom_range(1, f.size() - 1);
			while (f.size() > cut)
				void'(f.pop_back());
		end
	endfunction

	task automatic send_frame(input logic [7:0] f[$]);
		foreach (f[i])
			put(ACT_BYTE, f[i]);
		put(ACT_END, $urandom);
	endtask

	// Pull the answer out: usually all of it, sometimes past the end, sometimes only part
	task automatic drain_reply();
		int unsigned left, n, r;
		left = mirror.tx_len - mirror.tx_ptr;
		r = $urandom % 100;
		if (r < 10)
			n = $urandom_range(0, left);
		else if (r < 25)
			n = left + $urandom_range(1, 2);
		else
			n = left;
		repeat (n) put(ACT_PULL, $urandom);
	endtask

	task automatic apply_phase(input int phase);
		case (phase)
			0: begin
				cfg_write(CFG_STATION_ID, 16'd1);
				cfg_write(CFG_COIL_BASE, 16'd0);
				cfg_write(CFG_COIL_COUNT, 16'd2048);
				cfg_write(CFG_REG_BASE, 16'd0);
				cfg_write(CFG_REG_COUNT, 16'd256);
			end
			1: begin
				// windows that run into the top of the address space
				cfg_write(CFG_STATION_ID, 16'd247);
				cfg_write(CFG_COIL_BASE, 16'hFFFF);
				cfg_write(CFG_REG_BASE, 16'hFF80);
			end
			2: begin
				// empty windows: every address is illegal
				cfg_write(CFG_STATION_ID, 16'd1);
				cfg_write(CFG_COIL_COUNT, 16'd0);
				cfg_write(CFG_REG_COUNT, 16'd0);
				cfg_write(CFG_COIL_BASE, 16'd0);
				cfg_write(CFG_REG_BASE, 16'd0);
			end
			3: begin
				cfg_write(CFG_STATION_ID, $urandom_range(1, 247));
				cfg_write(CFG_COIL_BASE, $urandom & 16'hFFFF);
				cfg_write(CFG_COIL_COUNT, $urandom_range(1, COIL_DEPTH));
				cfg_write(CFG_REG_BASE, $urandom & 16'hFFFF);
				cfg_write(CFG_REG_COUNT, $urandom_range(1, REG_DEPTH));
			end
			4: begin
				cfg_write(CFG_STATION_ID, 16'd128);
				cfg_write(CFG_COIL_BASE, 16'd100);
				cfg_write(CFG_COIL_COUNT, 16'd2048);
				cfg_write(CFG_REG_BASE, 16'hFF00);
				cfg_write(CFG_REG_COUNT, 16'd256);
			end
			default: begin
				cfg_write(CFG_STATION_ID, $urandom_range(1, 247));
				cfg_write(CFG_COIL_BASE, 16'd0);
				cfg_write(CFG_COIL_COUNT, 16'd8);
				cfg_write(CFG_REG_BASE, 16'hFFFF);
				cfg_write(CFG_REG_COUNT, 16'd1);
			end
		endcase
	endtask

	initial begin
		logic [7:0]  req [$];
		int unsigned target;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		action    = ACT_BYTE;
		rx_byte   = 8'h00;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_STATION_ID;
		cfg_wdata = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty frame, pull with nothing to pull, ignored action, then one coil write
		put(ACT_END, 8'h00);
		put(ACT_PULL, 8'hFF);
		put(ACT_SPARE, 8'hA5);
		req = '{8'd1, FC_WR_COIL, 8'h00, 8'h00, COIL_ON[15:8], COIL_ON[7:0]};
		add_crc(req, 0);
		send_frame(req);
		drain_reply();

		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			apply_phase(phase);
			// starve the output for a long spell so the block backs up its input
			if (phase == 1)
				hold_asks++;
			// one oversized frame
			if (phase == 3) begin
				repeat ($urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 6))
					put(ACT_BYTE, $urandom);
				put(ACT_END, $urandom);
				drain_reply();
			end
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				build_request(req);
				send_frame(req);
				drain_reply();
				if ($urandom % 25 == 0)
					put(ACT_SPARE, $urandom);
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (mirror.owed.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (mirror.errors == 0 && mirror.owed.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
